### rtl/bilinear_image_resampler_assert.svh
// Assertion macros for the resampler
`ifndef BILINEAR_IMAGE_RESAMPLER_ASSERT_SVH
`define BILINEAR_IMAGE_RESAMPLER_ASSERT_SVH
// Implication checked on every edge outside reset
`define BIR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bir check failed");
// Next-cycle implication
`define BIR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bir check failed");
`endif

### rtl/bir_pkg.sv
package bir_pkg;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 25;
  localparam logic [CfgIdxW-1:0] REG_SRC_WIDTH = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_X_STEP = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_Y_STEP = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CH_COUNT = 3'd4;
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [7:0] in_c0;
    logic [7:0] in_c1;
    logic [7:0] in_c2;
    logic [7:0] in_c3;
  } req_t;

  typedef struct packed {
    logic [7:0] out_c0;
    logic [7:0] out_c1;
    logic [7:0] out_c2;
    logic [7:0] out_c3;
    logic       in_range;
  } rsp_t;

  // Classified operation travelling from front to back
  typedef struct packed {
    logic        is_write;
    logic        in_range;
    logic [11:0] xl;
    logic [11:0] yl;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [2:0]  nch;
    logic [31:0] word;
  } op_t;
endpackage

### rtl/bir_req_if.sv
interface bir_req_if;
  logic valid;
  logic ready;
  bir_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/bir_rsp_if.sv
interface bir_rsp_if;
  logic valid;
  logic ready;
  bir_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/bir_front.sv
module bir_front #(
  parameter int unsigned MaxWidth = 512,
  parameter int unsigned MaxHeight = 512,
  parameter int unsigned MaxChannels = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [bir_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bir_pkg::CfgDataW-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  bir_pkg::req_t        in_req,
  output logic                 op_valid,
  input  logic                 op_ready,
  output bir_pkg::op_t         op
);
  import bir_pkg::*;
  typedef enum logic [1:0] {S_IDLE, S_MUL, S_CLS} st_t;
  st_t st_r;
  logic [9:0]  w_r, h_r;
  logic [24:0] xs_r, ys_r;
  logic [2:0]  ch_r;
  req_t        req_r;
  logic [36:0] px_r, py_r;
  logic [12:0] w_eff, h_eff;
  logic [2:0]  nch;
  logic        wr_ok, rng;

  always_comb begin
    w_eff = ({3'd0, w_r} > 13'(MaxWidth)) ? 13'(MaxWidth) : {3'd0, w_r};
    h_eff = ({3'd0, h_r} > 13'(MaxHeight)) ? 13'(MaxHeight) : {3'd0, h_r};
    nch = (ch_r > 3'(MaxChannels)) ? 3'(MaxChannels) : ch_r;
    wr_ok = ({1'b0, req_r.pos_x} < w_eff) && ({1'b0, req_r.pos_y} < h_eff);
    rng = (w_eff != 13'd0) && (h_eff != 13'd0) &&
          (px_r <= 37'({w_eff - 13'd1, 16'd0})) &&
          (py_r <= 37'({h_eff - 13'd1, 16'd0}));
  end

  assign in_ready = (st_r == S_IDLE);
  assign op_valid = (st_r == S_CLS) && (req_r.req_type == REQ_SAMPLE || wr_ok);
  always_comb begin
    op.is_write = (req_r.req_type == REQ_WRITE);
    op.in_range = rng;
    op.xl = op.is_write ? req_r.pos_x : px_r[27:16];
    op.yl = op.is_write ? req_r.pos_y : py_r[27:16];
    op.fx = px_r[15:0];
    op.fy = py_r[15:0];
    op.nch = nch;
    op.word = {req_r.in_c3, req_r.in_c2, req_r.in_c1, req_r.in_c0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      w_r <= 10'd512; h_r <= 10'd512;
      xs_r <= 25'd65536; ys_r <= 25'd65536; ch_r <= 3'd3;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SRC_WIDTH:  w_r <= cfg_data[9:0];
          REG_SRC_HEIGHT: h_r <= cfg_data[9:0];
          REG_X_STEP:     xs_r <= cfg_data;
          REG_Y_STEP:     ys_r <= cfg_data;
          REG_CH_COUNT:   ch_r <= cfg_data[2:0];
          default: ;
        endcase
      end
      case (st_r)
        S_IDLE: if (in_valid) begin
          req_r <= in_req;
          st_r <= S_MUL;
        end
        S_MUL: begin
          px_r <= 37'(req_r.pos_x) * 37'(xs_r);
          py_r <= 37'(req_r.pos_y) * 37'(ys_r);
          st_r <= S_CLS;
        end
        S_CLS: if (op_ready || !op_valid) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/bir_fifo.sv
module bir_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bir_pkg::op_t  wr_op,
  output logic          rd_valid,
  input  logic          rd_ready,
  output bir_pkg::op_t  rd_op
);
  import bir_pkg::*;
  op_t q_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic push, pop;
  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_op = q_r[rp_r];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= wr_op;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

### rtl/bir_back.sv
module bir_back #(
  parameter int unsigned MaxWidth = 512,
  parameter int unsigned MaxHeight = 512
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         op_valid,
  output logic         op_ready,
  input  bir_pkg::op_t op,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output bir_pkg::rsp_t rsp
);
  import bir_pkg::*;
  localparam int unsigned XW = $clog2(MaxWidth);
  localparam int unsigned YW = $clog2(MaxHeight);
  localparam int unsigned Depth = 1 << (XW + YW);
  typedef enum logic [2:0] {S_IDLE, S_RD, S_WAIT, S_MUL, S_ACC, S_OUT} st_t;
  st_t st_r;
  logic [31:0] mem [Depth];
  logic [31:0] rd_r;
  logic [XW+YW-1:0] addr;
  logic [1:0] k_r;
  op_t op_r;
  logic [12:0] xr, yr;
  logic [12:0] cx, cy;
  logic [16:0] gx, gy, wx, wy;
  logic [33:0] wgt_r;
  logic        nz_r;
  logic [41:0] acc_r [4];
  logic [41:0] prod [4];
  rsp_t rsp_r;

  assign xr = {1'b0, op_r.xl} + ((op_r.fx != 16'd0) ? 13'd1 : 13'd0);
  assign yr = {1'b0, op_r.yl} + ((op_r.fy != 16'd0) ? 13'd1 : 13'd0);
  assign cx = k_r[0] ? xr : {1'b0, op_r.xl};
  assign cy = k_r[1] ? yr : {1'b0, op_r.yl};
  assign gx = 17'h10000 - {1'b0, op_r.fx};
  assign gy = 17'h10000 - {1'b0, op_r.fy};
  assign wx = k_r[0] ? {1'b0, op_r.fx} : gx;
  assign wy = k_r[1] ? {1'b0, op_r.fy} : gy;
  assign addr = {cy[YW-1:0], cx[XW-1:0]};
  assign op_ready = (st_r == S_IDLE);
  assign rsp_valid = (st_r == S_OUT);
  assign rsp = rsp_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      prod[c] = 42'(rd_r[8*c +: 8]) * 42'(wgt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && op_valid && op.is_write)
      mem[{op.yl[YW-1:0], op.xl[XW-1:0]}] <= op.word;
    if (st_r == S_RD) rd_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (op_valid && !op.is_write) begin
          op_r <= op;
          k_r <= 2'd0;
          for (int c = 0; c < 4; c++) acc_r[c] <= '0;
          st_r <= op.in_range ? S_RD : S_ACC;
        end
        S_RD: begin
          // hold weight and whether the neighbour lies in the store
          wgt_r <= 34'(wx) * 34'(wy);
          nz_r <= (cx < 13'(MaxWidth)) && (cy < 13'(MaxHeight));
          st_r <= S_MUL;
        end
        S_MUL: begin
          if (nz_r) for (int c = 0; c < 4; c++) acc_r[c] <= acc_r[c] + prod[c];
          k_r <= k_r + 2'd1;
          st_r <= (k_r == 2'd3) ? S_ACC : S_RD;
        end
        S_ACC: begin
          rsp_r.in_range <= op_r.in_range;
          rsp_r.out_c0 <= (op_r.in_range && op_r.nch > 3'd0) ? acc_r[0][39:32] : 8'd0;
          rsp_r.out_c1 <= (op_r.in_range && op_r.nch > 3'd1) ? acc_r[1][39:32] : 8'd0;
          rsp_r.out_c2 <= (op_r.in_range && op_r.nch > 3'd2) ? acc_r[2][39:32] : 8'd0;
          rsp_r.out_c3 <= (op_r.in_range && op_r.nch > 3'd3) ? acc_r[3][39:32] : 8'd0;
          st_r <= S_OUT;
        end
        S_OUT: if (rsp_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/bilinear_image_resampler.sv
// Channel  Dir  Handshake          Payload
// in_      in   in_valid/in_ready  req_type, pos_x, pos_y, in_c0..in_c3
// out_     out  out_valid/out_ready out_c0..out_c3, in_range
// cfg_     in   cfg_we             cfg_index, cfg_data
// The front captures, multiplies and classifies each request (S_IDLE, S_MUL, S_CLS)
// and takes no new request until the last has left S_CLS; a write then goes through
// the queue to the store. An in-range sample holds the back for one store read and
// one multiply-accumulate per neighbour (S_RD, S_MUL), then S_ACC and S_OUT; a
// position beyond the image goes straight from S_IDLE to S_ACC and S_OUT.
// Reset (rst_n, synchronous) restores register defaults; the store is not cleared.
module bilinear_image_resampler #(
  parameter int unsigned MAX_WIDTH = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [bir_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [bir_pkg::CfgDataW-1:0] cfg_data,
  bir_req_if.sink   in_ch,
  bir_rsp_if.source out_ch
);
  import bir_pkg::*;
  `include "bilinear_image_resampler_assert.svh"

  logic f_valid, f_ready, b_valid, b_ready;
  op_t  f_op, b_op;

  // Classify each request and form the source position
  bir_front #(.MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT),
              .MaxChannels(MAX_CHANNELS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_req(in_ch.payload),
    .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
  );

  // Decouple the two halves
  bir_fifo u_fifo (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_op(f_op),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_op(b_op)
  );

  // Store pixels and blend neighbours
  bir_back #(.MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT)) u_back (
    .clk, .rst_n, .op_valid(b_valid), .op_ready(b_ready), .op(b_op),
    .rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready), .rsp(out_ch.payload)
  );

  `BIR_ASSERT_IMP(a_oor_zero, out_ch.valid && !out_ch.payload.in_range,
    out_ch.payload.out_c0 == 8'd0 && out_ch.payload.out_c3 == 8'd0)
  `BIR_ASSERT_NXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid)
  `BIR_ASSERT_IMP(a_q_handoff, b_valid && b_ready, !out_ch.valid)
endmodule

### dv/tb_bilinear_image_resampler.sv
module tb_bilinear_image_resampler;
  timeunit 1ns;
  timeprecision 1ps;

  import bir_pkg::*;

  localparam int unsigned COLS = 512;
  localparam int unsigned ROWS = 512;
  localparam int unsigned CHANS = 4;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  // a write still passes the front, queue and back after acceptance; allow plenty
  // before a register write
  localparam int unsigned SETTLE_CYCLES = 40;

  // Mirror of the resampler: registers, pixel store and the queue of
  // results still owed by the block.
  class resample_board;
    int unsigned width_r, height_r, xstep_r, ystep_r, chans_r;
    logic [31:0] pix [COLS*ROWS];
    bit seen [COLS*ROWS];
    rsp_t owed[$];
    int errors;

    function new();
      width_r = 512;
      height_r = 512;
      xstep_r = 65536;
      ystep_r = 65536;
      chans_r = 3;
      errors = 0;
    endfunction

    function int unsigned eff_w();
      return width_r > COLS ? COLS : width_r;
    endfunction

    function int unsigned eff_h();
      return height_r > ROWS ? ROWS : height_r;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        REG_SRC_WIDTH:  width_r = val[9:0];
        REG_SRC_HEIGHT: height_r = val[9:0];
        REG_X_STEP:     xstep_r = val[24:0];
        REG_Y_STEP:     ystep_r = val[24:0];
        REG_CH_COUNT:   chans_r = val[2:0];
        default: ;
      endcase
    endfunction

    // Blend the four neighbours of a sample; the return value tells whether
    // every pixel it touches has been written.
    function bit blend(req_t r, output rsp_t o);
      longint unsigned px, py, fx, fy, gx, gy, sum;
      int unsigned w, h, xl, yl, xr, yr, nch, addr;
      logic [31:0] p [4];
      int unsigned cx [4];
      int unsigned cy [4];
      logic [7:0] v [4];
      bit ok;
      o = '0;
      w = eff_w();
      h = eff_h();
      px = longint'(r.pos_x) * longint'(xstep_r);
      py = longint'(r.pos_y) * longint'(ystep_r);
      if (w == 0 || h == 0 || px > (longint'(w - 1) << 16) ||
          py > (longint'(h - 1) << 16)) begin
        return 1'b1;
      end
      o.in_range = 1'b1;
      xl = 32'(px >> 16);
      yl = 32'(py >> 16);
      fx = px & 64'hFFFF;
      fy = py & 64'hFFFF;
      gx = 65536 - fx;
      gy = 65536 - fy;
      xr = (fx != 0) ? xl + 1 : xl;
      yr = (fy != 0) ? yl + 1 : yl;
      cx = '{xl, xr, xl, xr};
      cy = '{yl, yl, yr, yr};
      ok = 1'b1;
      for (int k = 0; k < 4; k++) begin
        addr = cy[k] * COLS + cx[k];
        if (!seen[addr]) ok = 1'b0;
        p[k] = pix[addr];
      end
      nch = chans_r > CHANS ? CHANS : chans_r;
      for (int c = 0; c < 4; c++) begin
        v[c] = '0;
        if (c < nch) begin
          sum = longint'(p[0][8*c +: 8]) * gx * gy + longint'(p[1][8*c +: 8]) * fx * gy +
                longint'(p[2][8*c +: 8]) * gx * fy + longint'(p[3][8*c +: 8]) * fx * fy;
          v[c] = sum[39:32];
        end
      end
      o.out_c0 = v[0];
      o.out_c1 = v[1];
      o.out_c2 = v[2];
      o.out_c3 = v[3];
      return ok;
    endfunction

    function void note_request(req_t r);
      rsp_t o;
      if (r.req_type == REQ_WRITE) begin
        if (r.pos_x < eff_w() && r.pos_y < eff_h()) begin
          pix[r.pos_y * COLS + r.pos_x] = {r.in_c3, r.in_c2, r.in_c1, r.in_c0};
          seen[r.pos_y * COLS + r.pos_x] = 1'b1;
        end
      end else begin
        void'(blend(r, o));
        owed = {owed, o};
      end
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check_result(rsp_t got);
      rsp_t want;
      if (owed.size() == 0) begin
        report_mismatch("unexpected result, in_range", got.in_range, 0);
        return;
      end
      want = owed.pop_front();
      if (got.out_c0 !== want.out_c0) report_mismatch("out_c0", got.out_c0, want.out_c0);
      if (got.out_c1 !== want.out_c1) report_mismatch("out_c1", got.out_c1, want.out_c1);
      if (got.out_c2 !== want.out_c2) report_mismatch("out_c2", got.out_c2, want.out_c2);
      if (got.out_c3 !== want.out_c3) report_mismatch("out_c3", got.out_c3, want.out_c3);
      if (got.in_range !== want.in_range)
        report_mismatch("in_range", got.in_range, want.in_range);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  bir_req_if req_bus ();
  bir_rsp_if rsp_bus ();

  resample_board board = new();
  bit calm = 1'b0;       // no idling on either side while set
  int unsigned cycles = 0;

  bilinear_image_resampler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (req_bus),
    .out_ch    (rsp_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    req_bus.valid = 1'b0;
    req_bus.payload = '0;
    rsp_bus.ready = 1'b0;
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Result side: stall at random, then take one result and check it.
  always begin : result_sink
    int unsigned stall;
    if (!rst_n) begin
      @(posedge clk);
    end else begin
      stall = calm ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        rsp_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_bus.ready <= 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
      board.check_result(rsp_bus.payload);
    end
  end

  // Hand one request to the block; valid is left high so that a request
  // with no gap follows without a dip.
  task send_request(req_t r);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.payload <= r;
    do @(posedge clk); while (!req_bus.ready);
    board.note_request(r);
  endtask

  function req_t make_req(logic kind, int unsigned x, int unsigned y, logic [31:0] word);
    req_t r;
    r.req_type = kind;
    r.pos_x = 12'(x);
    r.pos_y = 12'(y);
    {r.in_c3, r.in_c2, r.in_c1, r.in_c0} = word;
    return r;
  endfunction

  // Drop valid, wait for every owed result, then let the pipe empty.
  task drain();
    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task load_config(int unsigned w, int unsigned h, int unsigned xs, int unsigned ys,
                   int unsigned ch);
    write_reg(REG_SRC_WIDTH, CfgDataW'(w));
    write_reg(REG_SRC_HEIGHT, CfgDataW'(h));
    write_reg(REG_X_STEP, CfgDataW'(xs));
    write_reg(REG_Y_STEP, CfgDataW'(ys));
    write_reg(REG_CH_COUNT, CfgDataW'(ch));
    // indexes past the register list must leave everything alone
    write_reg(3'd5 + 3'($urandom_range(0, 2)), CfgDataW'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One past the highest destination coordinate that still lands inside the image.
  function int unsigned reach(int unsigned size, int unsigned step);
    longint unsigned m;
    if (size == 0 || step == 0) return 4095;
    m = (longint'(size - 1) << 16) / step + 1;
    return m > 4095 ? 4095 : 32'(m);
  endfunction

  function int unsigned pick_pos(int unsigned lim);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return $urandom_range(0, 4095);
    if (roll < 5) return $urandom_range(0, lim < 15 ? lim : 15);
    return $urandom_range(0, lim);
  endfunction

  task run_phase(int unsigned w, int unsigned h, int unsigned xs, int unsigned ys,
                 int unsigned ch, int unsigned count);
    int unsigned ew, eh, fw, fh, xlim, ylim, tries;
    req_t r;
    rsp_t dummy;
    bit found;
    load_config(w, h, xs, ys, ch);
    ew = board.eff_w();
    eh = board.eff_h();
    fw = (ew < 8) ? ew : 8;
    fh = (eh < 8) ? eh : 8;
    // fill the image, or its top-left corner when it is large
    for (int y = 0; y < fh; y++)
      for (int x = 0; x < fw; x++)
        send_request(make_req(REQ_WRITE, x, y, $urandom));
    xlim = reach(ew, xs);
    ylim = reach(eh, ys);
    for (int n = 0; n < count; n++) begin
      found = 1'b0;
      if ($urandom_range(0, 3) != 0) begin
        for (tries = 0; tries < 20 && !found; tries++) begin
          r = make_req(REQ_SAMPLE, pick_pos(xlim), pick_pos(ylim), $urandom);
          found = board.blend(r, dummy);
        end
      end
      if (!found) begin
        if ($urandom_range(0, 7) == 0)
          r = make_req(REQ_WRITE, $urandom_range(0, 4095), $urandom_range(0, 4095), $urandom);
        else
          r = make_req(REQ_WRITE, $urandom_range(0, ew + 2), $urandom_range(0, eh + 2),
                       $urandom);
      end
      send_request(r);
    end
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: register defaults, corners of the store, ignored writes
    // and positions beyond the image.
    send_request(make_req(REQ_WRITE, 0, 0, 32'hFFFF_FFFF));
    send_request(make_req(REQ_WRITE, 1, 0, 32'h0000_0000));
    send_request(make_req(REQ_WRITE, 0, 1, 32'hA5A5_5A5A));
    send_request(make_req(REQ_WRITE, 1, 1, 32'h0102_8081));
    send_request(make_req(REQ_WRITE, 511, 511, 32'hFFFF_FFFF));
    send_request(make_req(REQ_WRITE, 512, 0, 32'h1234_5678));
    send_request(make_req(REQ_WRITE, 4095, 4095, 32'h8765_4321));
    send_request(make_req(REQ_SAMPLE, 0, 0, 32'hFFFF_FFFF));
    send_request(make_req(REQ_SAMPLE, 1, 1, 32'h0));
    send_request(make_req(REQ_SAMPLE, 1, 0, 32'h0));
    send_request(make_req(REQ_SAMPLE, 511, 511, 32'h0));
    send_request(make_req(REQ_SAMPLE, 512, 0, 32'h0));
    send_request(make_req(REQ_SAMPLE, 0, 512, 32'h0));
    send_request(make_req(REQ_SAMPLE, 4095, 4095, 32'h0));
    drain();

    // Half steps: one sample blends all four neighbours, one lands on a pixel, one lies beyond the image.
    load_config(2, 2, 32768, 32768, 4);
    send_request(make_req(REQ_SAMPLE, 1, 1, 32'h0));
    send_request(make_req(REQ_SAMPLE, 2, 2, 32'h0));
    send_request(make_req(REQ_SAMPLE, 3, 0, 32'h0));
    drain();

    run_phase(512, 512, 65536, 65536, 3, 60);
    calm = 1'b1;
    run_phase(5, 4, 32'h0C000, 32'h08000, 4, 80);
    calm = 1'b0;
    run_phase(0, 7, 65536, 65536, 0, 40);
    run_phase(1023, 1, 1, 0, 7, 60);
    run_phase(1, 1, 32'h1FF_FFFF, 32'h1FF_FFFF, 1, 50);
    run_phase(1, 1, 0, 0, 2, 40);
    for (int k = 0; k < 3; k++) begin
      calm = (k == 1);
      run_phase($urandom_range(2, 20), $urandom_range(2, 20), $urandom_range(16384, 200000),
                $urandom_range(16384, 200000), $urandom_range(1, 4), 60);
    end
    calm = 1'b0;
    run_phase(1, 1023, 0, $urandom_range(1, 70000), 5, 60);

    if (board.owed.size() != 0)
      board.report_mismatch("results never returned", 0, board.owed.size());
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/bir_pkg.sv
rtl/bir_req_if.sv
rtl/bir_rsp_if.sv
rtl/bir_front.sv
rtl/bir_fifo.sv
rtl/bir_back.sv
rtl/bilinear_image_resampler.sv
dv/tb_bilinear_image_resampler.sv
